/* rtl/core/mpq_pkg.sv */
`default_nettype none
package mpq_pkg;

  // fixed field widths of the result beat
  localparam int KEY_W        = 32;
  localparam int STATUS_W     = 2;
  localparam int OUT_HANDLE_W = 16;
  localparam int COUNT_W      = 5;

  // command codes
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    STAT_INSERTED = 2'd0,
    STAT_REMOVED  = 2'd1,
    STAT_EMPTY    = 2'd2,
    STAT_FULL     = 2'd3
  } status_t;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_PLACE,
    S_POP
  } state_t;

endpackage
`default_nettype wire

/* rtl/core/max_priority_queue.sv */
`default_nettype none
// Max priority queue of CAPACITY entries, each a signed 32-bit key with a
// HANDLE_BITS handle. Every input beat (insert or remove largest) gives exactly
// one result beat with a status, the removed key and handle (zero unless an
// entry was removed) and the entry count afterwards, cut to five bits. Among
// equal keys the newest insert leaves first. An insert on a full queue is
// rejected with the full status and leaves the queue as it was. The entries sit
// in one single-port-read memory in ascending key order, so the largest key is
// always at the top of the occupied range and a remove is one registered read.
// An insert walks down from the top, moving each larger entry up by one slot
// per cycle through the shared key comparator. A full reject, an empty remove
// and an insert into an empty queue finish straight from the idle state. The
// block takes one item at a time; a finished result sits in the output
// register, and the next item is taken in the same cycle the result is
// collected. There is no clearing pass after reset: only occupied slots are
// ever read.
module max_priority_queue #(
  parameter int CAPACITY    = 16,
  parameter int HANDLE_BITS = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // input channel
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic                              in_cmd,
  input  wire logic [mpq_pkg::KEY_W-1:0]         in_key,
  input  wire logic [HANDLE_BITS-1:0]            in_handle,
  // result channel
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic      [mpq_pkg::STATUS_W-1:0]      out_status,
  output logic      [mpq_pkg::KEY_W-1:0]         out_key,
  output logic      [mpq_pkg::OUT_HANDLE_W-1:0]  out_handle,
  output logic      [mpq_pkg::COUNT_W-1:0]       out_count
);

  import mpq_pkg::*;

  localparam int IDX_W  = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int ENTRY_W = KEY_W + HANDLE_BITS;

  // sequencer state
  state_t                 state_r, state_nxt;
  logic [CNT_W-1:0]       count_r, count_nxt;
  logic [IDX_W-1:0]       ptr_r, ptr_nxt;           // slot awaiting a write
  logic [KEY_W-1:0]       key_r;                    // key being inserted
  logic [HANDLE_BITS-1:0] handle_r;

  // result register
  logic                    out_valid_r;
  logic [STATUS_W-1:0]     out_status_r;
  logic [KEY_W-1:0]        out_key_r;
  logic [OUT_HANDLE_W-1:0] out_handle_r;
  logic [COUNT_W-1:0]      out_count_r;

  // result being finished this cycle
  logic                    done;
  status_t                 res_status;
  logic [KEY_W-1:0]        res_key;
  logic [OUT_HANDLE_W-1:0] res_handle;

  // entry memory port
  logic               mem_we, mem_re;
  logic [IDX_W-1:0]   mem_waddr, mem_raddr;
  logic [ENTRY_W-1:0] mem_wdata, mem_rdata;

  logic                   in_fire;
  logic [KEY_W-1:0]       rd_key;
  logic [HANDLE_BITS-1:0] rd_handle;
  logic                   rd_gt;                    // stored key beats new key
  logic [ENTRY_W-1:0]     new_entry;

  mpq_store #(
    .DEPTH (CAPACITY),
    .WIDTH (ENTRY_W)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // one item at a time, and only with the result slot free or being emptied
  assign in_ready = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign in_fire  = in_valid && in_ready;

  assign rd_key    = mem_rdata[ENTRY_W-1 -: KEY_W];
  assign rd_handle = mem_rdata[HANDLE_BITS-1:0];
  // shared comparator: strictly greater keeps the newest equal key on top
  assign rd_gt     = $signed(rd_key) > $signed(key_r);
  assign new_entry = {key_r, handle_r};

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    ptr_nxt    = ptr_r;
    done       = 1'b0;
    res_status = STAT_INSERTED;
    res_key    = '0;
    res_handle = '0;
    mem_we     = 1'b0;
    mem_waddr  = ptr_r;
    mem_wdata  = new_entry;
    mem_re     = 1'b0;
    mem_raddr  = IDX_W'(count_r - CNT_W'(1));

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_cmd == CMD_INSERT) begin
            if (count_r == CNT_W'(CAPACITY)) begin
              done       = 1'b1;
              res_status = STAT_FULL;
            end else if (count_r == '0) begin
              // first entry goes straight to the bottom slot
              mem_we     = 1'b1;
              mem_waddr  = '0;
              mem_wdata  = {in_key, in_handle};
              done       = 1'b1;
              res_status = STAT_INSERTED;
              count_nxt  = count_r + CNT_W'(1);
            end else begin
              // fetch the top entry and start walking down
              mem_re    = 1'b1;
              ptr_nxt   = IDX_W'(count_r);
              state_nxt = S_SCAN;
            end
          end else begin
            if (count_r == '0) begin
              done       = 1'b1;
              res_status = STAT_EMPTY;
            end else begin
              mem_re    = 1'b1;
              state_nxt = S_POP;
            end
          end
        end
      end

      S_SCAN: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_r;
        if (rd_gt) begin
          // larger entry moves up one slot
          mem_wdata = mem_rdata;
          ptr_nxt   = ptr_r - IDX_W'(1);
          if (ptr_r == IDX_W'(1)) begin
            state_nxt = S_PLACE;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = ptr_r - IDX_W'(2);
          end
        end else begin
          mem_wdata  = new_entry;
          done       = 1'b1;
          res_status = STAT_INSERTED;
          count_nxt  = count_r + CNT_W'(1);
          state_nxt  = S_IDLE;
        end
      end

      S_PLACE: begin
        // every stored key was larger: new entry takes the bottom slot
        mem_we     = 1'b1;
        mem_waddr  = '0;
        mem_wdata  = new_entry;
        done       = 1'b1;
        res_status = STAT_INSERTED;
        count_nxt  = count_r + CNT_W'(1);
        state_nxt  = S_IDLE;
      end

      S_POP: begin
        done       = 1'b1;
        res_status = STAT_REMOVED;
        res_key    = rd_key;
        res_handle = OUT_HANDLE_W'(rd_handle);
        count_nxt  = count_r - CNT_W'(1);
        state_nxt  = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      ptr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ptr_r   <= ptr_nxt;
      if (done) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      key_r    <= in_key;
      handle_r <= in_handle;
    end
    if (done) begin
      out_status_r <= res_status;
      out_key_r    <= res_key;
      out_handle_r <= res_handle;
      out_count_r  <= COUNT_W'(count_nxt);
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_key    = out_key_r;
  assign out_handle = out_handle_r;
  assign out_count  = out_count_r;

`ifndef SYNTH
  // occupancy never passes the capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  // the walk stays inside the occupied range plus the free slot above it
  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (ptr_r != '0 && CNT_W'(ptr_r) <= count_r))
    else $error("insert walk left the occupied range");

  // a completed insert adds exactly one entry
  a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
    (done && res_status == STAT_INSERTED) |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("insert did not grow the queue by one");

  // a remove that finds nothing reports zero entries and zero payload
  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == STAT_EMPTY) |->
      (out_count_r == '0 && out_key_r == '0 && out_handle_r == '0))
    else $error("empty remove reported data");
`endif

endmodule
`default_nettype wire

/* rtl/core/mpq_store.sv */
`default_nettype none
module mpq_store #(
  parameter int DEPTH  = 16,
  parameter int WIDTH  = 48,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

/* tb/max_priority_queue_tb.sv */
module max_priority_queue_tb;
  import mpq_pkg::*;

  localparam int CAPACITY    = 16;
  localparam int HANDLE_BITS = 16;
  // cycles with no beat on either side before the run is called hung
  localparam int STALL_LIMIT = 1000;
  // size of one random block of items
  localparam int BLOCK_ITEMS = 40;

  // one input beat as the sender sees it
  typedef struct packed {
    logic                   cmd;
    logic [KEY_W-1:0]       key;
    logic [HANDLE_BITS-1:0] handle;
  } pq_item_t;

  // one result beat, field for field
  typedef struct packed {
    status_t                 status;
    logic [KEY_W-1:0]        key;
    logic [OUT_HANDLE_W-1:0] handle;
    logic [COUNT_W-1:0]      count;
  } pq_result_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic                    in_cmd = CMD_INSERT;
  logic [KEY_W-1:0]        in_key = '0;
  logic [HANDLE_BITS-1:0]  in_handle = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [STATUS_W-1:0]     out_status;
  logic [KEY_W-1:0]        out_key;
  logic [OUT_HANDLE_W-1:0] out_handle;
  logic [COUNT_W-1:0]      out_count;

  // items waiting for the driver, and results waiting for the monitor
  pq_item_t   feed_q[$];
  pq_result_t want_q[$];

  // shadow copy of the queue contents, largest key in slot 0
  logic signed [KEY_W-1:0] shadow_keys[CAPACITY];
  logic [HANDLE_BITS-1:0]  shadow_handles[CAPACITY];
  int                      shadow_fill = 0;

  logic in_fire = 1'b0;   // input beat taken at the last rising edge
  logic calm = 1'b0;      // no idling on either side once set
  int   send_gap = 0;
  int   recv_gap = 0;
  int   items_issued = 0;
  int   results_seen = 0;
  int   n_mismatch = 0;
  int   stall_cycles = 0;
  int   n_status[4] = '{0, 0, 0, 0};

  max_priority_queue #(
    .CAPACITY    (CAPACITY),
    .HANDLE_BITS (HANDLE_BITS)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_cmd     (in_cmd),
    .in_key     (in_key),
    .in_handle  (in_handle),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_status (out_status),
    .out_key    (out_key),
    .out_handle (out_handle),
    .out_count  (out_count)
  );

  always #5 clk = ~clk;

  // applies one item to the shadow queue and gives the result it should cause
  function automatic pq_result_t sorted_queue_apply(pq_item_t it);
    pq_result_t              r;
    logic signed [KEY_W-1:0] k;
    int                      pos;
    r = '{STAT_INSERTED, '0, '0, '0};
    k = it.key;
    if (it.cmd == CMD_INSERT) begin
      if (shadow_fill >= CAPACITY) begin
        // full: rejected, contents untouched
        r.status = STAT_FULL;
      end else begin
        // walk past every strictly larger key, so a new key lands ahead of its equals
        pos = 0;
        while (pos < shadow_fill && shadow_keys[pos] > k) pos++;
        for (int i = shadow_fill; i > pos; i--) begin
          shadow_keys[i]    = shadow_keys[i-1];
          shadow_handles[i] = shadow_handles[i-1];
        end
        shadow_keys[pos]    = k;
        shadow_handles[pos] = it.handle;
        shadow_fill++;
      end
    end else begin
      if (shadow_fill == 0) begin
        r.status = STAT_EMPTY;
      end else begin
        // pop the head and close the gap
        r.status = STAT_REMOVED;
        r.key    = shadow_keys[0];
        r.handle = OUT_HANDLE_W'(shadow_handles[0]);
        for (int i = 1; i < shadow_fill; i++) begin
          shadow_keys[i-1]    = shadow_keys[i];
          shadow_handles[i-1] = shadow_handles[i];
        end
        shadow_fill--;
      end
    end
    r.count = COUNT_W'(shadow_fill);
    return r;
  endfunction

  task automatic note_mismatch(string what, pq_result_t w, pq_result_t g);
    n_mismatch++;
    if (n_mismatch <= 10)
      $display("%0t mismatch (%s): expected status %0d key %h handle %h count %0d, got status %0d key %h handle %h count %0d",
               $time, what, w.status, w.key, w.handle, w.count,
               g.status, g.key, g.handle, g.count);
  endtask

  task automatic queue_item(logic cmd, logic [KEY_W-1:0] key, logic [HANDLE_BITS-1:0] handle);
    feed_q.push_back('{cmd, key, handle});
    items_issued++;
  endtask

  // input driver: changes on the falling edge, holds a beat until it is taken
  always @(negedge clk) begin : feed_drive
    pq_item_t nxt;
    if (rst_n) begin
      if (in_valid && !in_fire) begin
        // beat still waiting for ready, leave it alone
      end else if (send_gap > 0) begin
        in_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (!calm && feed_q.size() > 0 && $urandom_range(0, 11) == 0) begin
        // start an idle burst
        in_valid <= 1'b0;
        send_gap <= $urandom_range(0, 17);
      end else if (feed_q.size() > 0) begin
        nxt = feed_q.pop_front();
        in_valid  <= 1'b1;
        in_cmd    <= nxt.cmd;
        in_key    <= nxt.key;
        in_handle <= nxt.handle;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result side back-pressure in bursts
  always @(negedge clk) begin
    if (rst_n) begin
      if (calm) begin
        out_ready <= 1'b1;
        recv_gap  <= 0;
      end else if (recv_gap > 0) begin
        out_ready <= 1'b0;
        recv_gap  <= recv_gap - 1;
      end else if ($urandom_range(0, 9) == 0) begin
        out_ready <= 1'b0;
        recv_gap  <= $urandom_range(0, 17);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // monitor: samples both channels on the rising edge
  always @(posedge clk) begin : watch_beats
    pq_result_t got;
    pq_result_t want;
    if (!rst_n) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_valid && in_ready;
      if (out_valid && out_ready) begin
        got.status = status_t'(out_status);
        got.key    = out_key;
        got.handle = out_handle;
        got.count  = out_count;
        if (want_q.size() == 0) begin
          note_mismatch("unexpected beat", '{STAT_INSERTED, '0, '0, '0}, got);
        end else begin
          want = want_q.pop_front();
          results_seen++;
          n_status[want.status]++;
          if (got.status !== want.status || got.key !== want.key ||
              got.handle !== want.handle || got.count !== want.count)
            note_mismatch("wrong field", want, got);
        end
      end
      // the result of an item can never leave on the edge that takes it
      if (in_valid && in_ready)
        want_q.push_back(sorted_queue_apply('{in_cmd, in_key, in_handle}));
    end
  end

  // watchdog on cycles with no beat on either channel
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready))
        stall_cycles <= 0;
      else
        stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("hung: %0d items issued, %0d results seen", items_issued, results_seen);
        $display("max_priority_queue_tb: done, errors");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int                      pct;
    int                      pick;
    logic [KEY_W-1:0]        k;
    logic [HANDLE_BITS-1:0]  h;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: empty pop, extremes, ties, fill to capacity, reject, drain some
    queue_item(CMD_REMOVE, 32'hFFFF_FFFF, 16'hFFFF);
    queue_item(CMD_INSERT, 32'h7FFF_FFFF, 16'hFFFF);
    queue_item(CMD_INSERT, 32'h8000_0000, 16'h0000);
    queue_item(CMD_INSERT, 32'h0000_0000, 16'h1234);
    queue_item(CMD_INSERT, 32'hFFFF_FFFF, 16'hA5A5);
    queue_item(CMD_INSERT, 32'd5,         16'h0001);
    queue_item(CMD_INSERT, 32'd5,         16'h0002);
    queue_item(CMD_INSERT, 32'd5,         16'h0003);
    queue_item(CMD_INSERT, 32'd1,         16'h5A5A);
    queue_item(CMD_INSERT, 32'h7FFF_FFFF, 16'h0002);
    queue_item(CMD_INSERT, 32'h8000_0000, 16'h0003);
    queue_item(CMD_INSERT, -32'sd5,       16'h00F0);
    queue_item(CMD_INSERT, 32'd100,       16'h0F00);
    queue_item(CMD_INSERT, -32'sd100,     16'hF000);
    queue_item(CMD_INSERT, 32'd5,         16'h0004);
    queue_item(CMD_INSERT, 32'd2,         16'h7777);
    queue_item(CMD_INSERT, 32'd3,         16'h8888);
    // seventeenth insert meets a full queue
    queue_item(CMD_INSERT, 32'd50,        16'hBEEF);
    repeat (6) queue_item(CMD_REMOVE, $urandom, HANDLE_BITS'($urandom));

    // pause the sender until every result is back
    while (results_seen < items_issued) @(posedge clk);

    // random blocks, each with its own insert bias so the fill swings end to end
    for (int blk = 0; blk < 12; blk++) begin
      if (blk == 6)
        while (results_seen < items_issued) @(posedge clk);
      case ($urandom_range(0, 4))
        0: pct = 10;
        1: pct = 30;
        2: pct = 50;
        3: pct = 75;
        default: pct = 90;
      endcase
      for (int n = 0; n < BLOCK_ITEMS; n++) begin
        h    = HANDLE_BITS'($urandom);
        pick = $urandom_range(0, 9);
        if (pick < 5) begin
          k = $urandom;
        end else if (pick < 8) begin
          // narrow range for plenty of equal keys
          k = KEY_W'($signed($urandom_range(0, 8)) - 4);
        end else begin
          case ($urandom_range(0, 5))
            0: k = 32'h7FFF_FFFF;
            1: k = 32'h8000_0000;
            2: k = 32'h0000_0000;
            3: k = 32'hFFFF_FFFF;
            4: k = 32'h7FFF_FFFE;
            default: k = 32'h8000_0001;
          endcase
        end
        if ($urandom_range(1, 100) <= pct)
          queue_item(CMD_INSERT, k, h);
        else
          queue_item(CMD_REMOVE, k, h);
      end
    end

    // last stretch runs without idling
    while (feed_q.size() > 50) @(posedge clk);
    calm = 1'b1;

    while (results_seen < items_issued) @(posedge clk);
    // longest insert walk plus margin
    repeat (CAPACITY + 4) @(posedge clk);

    $display("covered %0d items: %0d inserts, %0d removes, %0d rejected when full, %0d pops on empty",
             items_issued, n_status[STAT_INSERTED], n_status[STAT_REMOVED],
             n_status[STAT_FULL], n_status[STAT_EMPTY]);
    $display("mismatches: %0d, results outstanding: %0d", n_mismatch, want_q.size());
    if (n_mismatch == 0 && want_q.size() == 0)
      $display("max_priority_queue_tb: done, clean");
    else
      $display("max_priority_queue_tb: done, errors");
    $finish;
  end

endmodule
